// ===== src/curved_grid_point_mapper_unit_assert.svh =====
// Assertion macros for the curved grid point mapper.
// Uses clk and rst of the including module.
`ifndef CURVED_GRID_POINT_MAPPER_UNIT_ASSERT_SVH
`define CURVED_GRID_POINT_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define CGPM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgpm assertion failed");

// next-cycle implication
`define CGPM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cgpm assertion failed");

`endif

// ===== src/cgpm_pkg.sv =====
// Shared types, constants and helpers for the curved grid point mapper.
// No dependencies.
package cgpm_pkg;

  localparam int COORD_BITS_DEF = 9;
  localparam int CAM_W          = 9;
  localparam int GRID_W         = 12;
  localparam int CFG_W          = 63;
  localparam int CFG_IDX_W      = 4;
  localparam int COEF_W         = 21;
  localparam int NUM_CURVES     = 6;
  localparam int FRAC_BITS      = 20;
  localparam int B_SHIFT        = 8;
  localparam int C_SHIFT        = 12;
  // sized for the largest coordinate width (12 bits)
  localparam int CV_W           = 47;
  localparam int DIFF_W         = CV_W + 1;
  localparam int NUM_W          = DIFF_W + 13;
  localparam int LO_W           = DIFF_W / 2;
  localparam int HI_W           = DIFF_W - LO_W;
  localparam int QUO_W          = GRID_W;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = GRID_W'(320);
  localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = GRID_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP, REG_MID_ROW, REG_BOTTOM, REG_LEFT, REG_MID_COL, REG_RIGHT,
    REG_GRID_WIDTH, REG_GRID_HEIGHT
  } reg_index_t;

  typedef logic [NUM_CURVES-1:0][CFG_W-1:0] curve_bank_t;

  typedef struct packed {
    logic [CAM_W-1:0] cam_x;
    logic [CAM_W-1:0] cam_y;
  } req_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic              clamped;
    logic              degenerate;
  } rsp_t;

  typedef struct packed {
    logic signed [NUM_W-1:0]  num;
    logic signed [DIFF_W-1:0] den;
    logic                     degen;
  } axis_job_t;

  typedef struct packed {
    axis_job_t x;
    axis_job_t y;
  } job_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] packed_c,
                                                   input int idx);
    coef = $signed(packed_c[idx*COEF_W +: COEF_W]);
  endfunction

endpackage

// ===== src/cgpm_front.sv =====
// Front pipeline: curve evaluation, half selection, numerator/denominator build.
// Depends on cgpm_pkg.
module cgpm_front
  import cgpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req_data,
  input  curve_bank_t       curves,
  input  logic [GRID_W-1:0] grid_width,
  input  logic [GRID_W-1:0] grid_height,
  input  logic              full,
  output logic              push,
  output job_t              job
);

  localparam int T_W  = COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam int PA_W = COEF_W + SQ_W + 1;
  localparam int PB_W = COEF_W + T_W + 1;
  localparam int LAST = 6;

  logic [LAST:0] v;
  logic          fe;

  assign fe        = !v[LAST] || !full;
  assign req_ready = fe;
  assign push      = v[LAST] && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fe) begin
      v <= {v[LAST-1:0], req_valid};
    end
  end

  // index 0 = x, 1 = y
  logic        [T_W-1:0]    t0 [2];
  logic        [T_W-1:0]    t1 [2];
  logic        [SQ_W-1:0]   sq1 [2];
  logic        [T_W-1:0]    t2 [2];
  logic signed [PA_W-1:0]   pa2 [NUM_CURVES];
  logic signed [PB_W-1:0]   pb2 [NUM_CURVES];
  logic signed [COEF_W-1:0] cc2 [NUM_CURVES];
  logic signed [CV_W-1:0]   cv3 [NUM_CURVES];
  logic signed [CV_W-1:0]   p3 [2];
  logic [GRID_W-1:0]        size [2];

  assign size[0] = grid_width;
  assign size[1] = grid_height;

  always_ff @(posedge clk) begin
    if (fe) begin
      t0[0]  <= T_W'(req_data.cam_x);
      t0[1]  <= T_W'(req_data.cam_y);
      t1     <= t0;
      sq1[0] <= t0[0] * t0[0];
      sq1[1] <= t0[1] * t0[1];
      t2     <= t1;
      p3[0]  <= CV_W'({t2[0], {FRAC_BITS{1'b0}}});
      p3[1]  <= CV_W'({t2[1], {FRAC_BITS{1'b0}}});
    end
  end

  for (genvar i = 0; i < NUM_CURVES; i++) begin : g_curve
    localparam int TA = (i < 3) ? 0 : 1;
    always_ff @(posedge clk) begin
      if (fe) begin
        pa2[i] <= coef(curves[i], 0) * $signed({1'b0, sq1[TA]});
        pb2[i] <= coef(curves[i], 1) * $signed({1'b0, t1[TA]});
        cc2[i] <= coef(curves[i], 2);
        cv3[i] <= CV_W'(pa2[i]) + (CV_W'(pb2[i]) <<< B_SHIFT) + (CV_W'(cc2[i]) <<< C_SHIFT);
      end
    end
  end

  logic                     up4 [2];
  logic                     dg4 [2];
  logic signed [DIFF_W-1:0] den4 [2];
  logic signed [DIFF_W-1:0] dn4 [2];
  logic                     up5 [2];
  logic                     dg5 [2];
  logic signed [HI_W+GRID_W-1:0]   hh5 [2];
  logic        [LO_W+GRID_W-2:0]   hl5 [2];
  logic signed [HI_W+GRID_W:0]     sh5 [2];
  logic        [LO_W+GRID_W-1:0]   sl5 [2];
  logic signed [DIFF_W-1:0] den5_hold [2];
  logic signed [NUM_W-1:0]  num6 [2];
  logic signed [DIFF_W-1:0] den6 [2];
  logic                     dg6 [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    localparam int BASE = (ax == 0) ? 3 : 0;
    logic signed [DIFF_W-1:0] p_e, lo_e, mid_e, hi_e, den_c, dn_c;
    logic                     up_c;
    logic [GRID_W-2:0]        half;
    logic signed [NUM_W-1:0]  h_sum, s_sum;

    assign p_e   = DIFF_W'(p3[ax]);
    assign lo_e  = DIFF_W'(cv3[BASE]);
    assign mid_e = DIFF_W'(cv3[BASE+1]);
    assign hi_e  = DIFF_W'(cv3[BASE+2]);
    assign up_c  = p_e < mid_e;
    assign den_c = up_c ? mid_e - lo_e : hi_e - mid_e;
    assign dn_c  = up_c ? p_e - lo_e : hi_e - p_e;
    assign half  = size[ax][GRID_W-1:1];
    assign h_sum = (NUM_W'(hh5[ax]) <<< LO_W) + NUM_W'(hl5[ax]);
    assign s_sum = (NUM_W'(sh5[ax]) <<< LO_W) + NUM_W'(sl5[ax]);

    always_ff @(posedge clk) begin
      if (fe) begin
        up4[ax]  <= up_c;
        dg4[ax]  <= den_c == '0;
        den4[ax] <= den_c;
        dn4[ax]  <= dn_c;
        up5[ax]  <= up4[ax];
        dg5[ax]  <= dg4[ax];
        hh5[ax]  <= $signed({1'b0, half}) * $signed(dn4[ax][DIFF_W-1:LO_W]);
        hl5[ax]  <= half * dn4[ax][LO_W-1:0];
        sh5[ax]  <= $signed({1'b0, size[ax]}) * $signed(den4[ax][DIFF_W-1:LO_W]);
        sl5[ax]  <= size[ax] * den4[ax][LO_W-1:0];
        num6[ax] <= up5[ax] ? h_sum : s_sum - h_sum;
        den6[ax] <= den5_hold[ax];
        dg6[ax]  <= dg5[ax];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      den5_hold <= den4;
    end
  end

  assign job.x = '{num: num6[0], den: den6[0], degen: dg6[0]};
  assign job.y = '{num: num6[1], den: den6[1], degen: dg6[1]};

endmodule

// ===== src/cgpm_queue.sv =====
// Small register FIFO between the front and back pipelines.
// Depends on cgpm_pkg.
module cgpm_queue
  import cgpm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ===== src/cgpm_back.sv =====
// Back pipeline: bit-per-stage division, clamping and result register.
// Depends on cgpm_pkg.
module cgpm_back
  import cgpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  job_t              q_data,
  output logic              pop,
  input  logic [GRID_W-1:0] grid_width,
  input  logic [GRID_W-1:0] grid_height,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp_data
);

  localparam int DIV_LAST = QUO_W + 1;
  localparam int LAST     = DIV_LAST + 1;

  logic [LAST:0] v;
  logic          be;

  assign be        = !v[LAST] || rsp_ready;
  assign pop       = q_valid && be;
  assign rsp_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (be) begin
      v <= {v[LAST-1:0], q_valid};
    end
  end

  axis_job_t         in_job [2];
  logic [GRID_W-1:0] size [2];
  logic [GRID_W-1:0] res [2];
  logic              clp [2];
  logic              dgn [2];

  assign in_job[0] = q_data.x;
  assign in_job[1] = q_data.y;
  assign size[0]   = grid_width;
  assign size[1]   = grid_height;

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [NUM_W-1:0]  rem [DIV_LAST+1];
    logic [DIFF_W-1:0] ad  [DIV_LAST+1];
    logic [QUO_W-1:0]  qb  [DIV_LAST+1];
    logic              neg [DIV_LAST+1];
    logic              ovr [DIV_LAST+1];
    logic              dg  [DIV_LAST+1];

    always_ff @(posedge clk) begin
      if (be) begin
        rem[0] <= in_job[ax].num[NUM_W-1] ? NUM_W'(-in_job[ax].num) : NUM_W'(in_job[ax].num);
        ad[0]  <= in_job[ax].den[DIFF_W-1] ? DIFF_W'(-in_job[ax].den) : DIFF_W'(in_job[ax].den);
        neg[0] <= in_job[ax].num[NUM_W-1] ^ in_job[ax].den[DIFF_W-1];
        dg[0]  <= in_job[ax].degen;
        ovr[0] <= 1'b0;
        qb[0]  <= '0;
        rem[1] <= rem[0];
        ad[1]  <= ad[0];
        neg[1] <= neg[0];
        dg[1]  <= dg[0];
        ovr[1] <= rem[0] >= NUM_W'({ad[0], {QUO_W{1'b0}}});
        qb[1]  <= '0;
      end
    end

    for (genvar k = 2; k <= DIV_LAST; k++) begin : g_div
      localparam int BIT = DIV_LAST - k;
      logic [NUM_W-1:0] cand;
      logic             ge;
      assign cand = NUM_W'(ad[k-1]) << BIT;
      assign ge   = rem[k-1] >= cand;
      always_ff @(posedge clk) begin
        if (be) begin
          rem[k] <= ge ? rem[k-1] - cand : rem[k-1];
          qb[k]  <= qb[k-1] | (QUO_W'(ge) << BIT);
          ad[k]  <= ad[k-1];
          neg[k] <= neg[k-1];
          ovr[k] <= ovr[k-1];
          dg[k]  <= dg[k-1];
        end
      end
    end

    always_comb begin
      res[ax] = qb[DIV_LAST];
      clp[ax] = 1'b0;
      dgn[ax] = 1'b0;
      if (dg[DIV_LAST]) begin
        res[ax] = '0;
        dgn[ax] = 1'b1;
      end else if (neg[DIV_LAST]) begin
        res[ax] = '0;
        clp[ax] = ovr[DIV_LAST] || (qb[DIV_LAST] != '0);
      end else if (ovr[DIV_LAST] || (qb[DIV_LAST] > size[ax])) begin
        res[ax] = size[ax];
        clp[ax] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      rsp_data.grid_x     <= res[0];
      rsp_data.grid_y     <= res[1];
      rsp_data.clamped    <= clp[0] || clp[1];
      rsp_data.degenerate <= dgn[0] || dgn[1];
    end
  end

endmodule

// ===== src/curved_grid_point_mapper_unit.sv =====
// Curved grid point mapper: top level with configuration registers.
// Depends on cgpm_pkg, cgpm_front, cgpm_queue, cgpm_back and the assertion header.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one camera point per request.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns one grid point per request,
//    in request order, with clamped and degenerate flags.
//  - cfg_write/cfg_index/cfg_data write the six curve registers and the grid
//    size; write only while no request is in flight. Unknown indexes are dropped.
//  - Throughput: one request per cycle unless the receiver stalls; every stage is
//    pipelined, including the divider, which resolves one quotient bit per stage.
//  - Pipeline: a request passes 7 front stages, the queue and 15 back stages
//    including the output register.
//  - A stalled receiver freezes the back pipeline; the 4-entry queue keeps the
//    front running until it fills, then req_ready drops.
//  - Reset clears the pipelines and queue, curves to 0, grid to 320 by 200.
`include "curved_grid_point_mapper_unit_assert.svh"

module curved_grid_point_mapper_unit
  import cgpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  curve_bank_t       curves;
  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      curves      <= '0;
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOP:         curves[REG_TOP]     <= cfg_data;
        REG_MID_ROW:     curves[REG_MID_ROW] <= cfg_data;
        REG_BOTTOM:      curves[REG_BOTTOM]  <= cfg_data;
        REG_LEFT:        curves[REG_LEFT]    <= cfg_data;
        REG_MID_COL:     curves[REG_MID_COL] <= cfg_data;
        REG_RIGHT:       curves[REG_RIGHT]   <= cfg_data;
        REG_GRID_WIDTH:  grid_width          <= cfg_data[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_height         <= cfg_data[GRID_W-1:0];
        default:         grid_width          <= grid_width;
      endcase
    end
  end

  logic q_push, q_full, q_pop, q_not_empty;
  job_t q_in, q_out;
  logic rsp_in_range;

  assign rsp_in_range = (rsp_data.grid_x <= grid_width) && (rsp_data.grid_y <= grid_height);

  cgpm_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .curves      (curves),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .full        (q_full),
    .push        (q_push),
    .job         (q_in)
  );

  cgpm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  cgpm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_data      (q_out),
    .pop         (q_pop),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data)
  );

  `CGPM_ASSERT_IMPL(a_rsp_in_range, rsp_valid, rsp_in_range)
  `CGPM_ASSERT_IMPL(a_reset_empty, $past(rst), !rsp_valid && !q_not_empty)
  `CGPM_ASSERT_NEXT(a_push_lands, q_push && !q_pop, q_not_empty)

endmodule

// ===== verif/curved_grid_point_mapper_checker.sv =====
`timescale 1ns / 100ps
// Checker for the curved grid point mapper: mirrors register writes, predicts
// each grid point from accepted requests and compares responses in order.
// Depends on cgpm_pkg.
module curved_grid_point_mapper_checker
  import cgpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  req_t                 req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_t                 rsp_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  logic [CFG_W-1:0]  curve_regs [NUM_CURVES];
  logic [GRID_W-1:0] width_reg;
  logic [GRID_W-1:0] height_reg;
  rsp_t              expected_points [$];

  initial errors = 0;
  assign pending = expected_points.size();

  function automatic longint curve_val(input logic [CFG_W-1:0] p, input longint t);
    longint a, b, c;
    a = longint'($signed(p[20:0]));
    b = longint'($signed(p[41:21]));
    c = longint'($signed(p[62:42]));
    return a * t * t + b * t * 256 + c * 4096;
  endfunction

  function automatic longint map_axis(input longint p, input longint lo,
                                      input longint mid, input longint hi,
                                      input longint size, inout bit clamp,
                                      inout bit degen);
    longint half, den, r;
    half = size / 2;
    if (p < mid) begin
      den = mid - lo;
      if (den == 0) begin
        degen = 1'b1;
        return 0;
      end
      r = (half * (p - lo)) / den;
    end else begin
      den = hi - mid;
      if (den == 0) begin
        degen = 1'b1;
        return 0;
      end
      r = (size * den - half * (hi - p)) / den;
    end
    if (r < 0) begin
      clamp = 1'b1;
      r = 0;
    end
    if (r > size) begin
      clamp = 1'b1;
      r = size;
    end
    return r;
  endfunction

  function automatic rsp_t predict_point(input req_t rq);
    longint x, y, gx, gy;
    bit clamp, degen;
    rsp_t res;
    x = longint'(rq.cam_x);
    y = longint'(rq.cam_y);
    clamp = 1'b0;
    degen = 1'b0;
    gy = map_axis(y << FRAC_BITS, curve_val(curve_regs[REG_TOP], x),
                  curve_val(curve_regs[REG_MID_ROW], x),
                  curve_val(curve_regs[REG_BOTTOM], x),
                  longint'(height_reg), clamp, degen);
    gx = map_axis(x << FRAC_BITS, curve_val(curve_regs[REG_LEFT], y),
                  curve_val(curve_regs[REG_MID_COL], y),
                  curve_val(curve_regs[REG_RIGHT], y),
                  longint'(width_reg), clamp, degen);
    res.grid_x = gx[GRID_W-1:0];
    res.grid_y = gy[GRID_W-1:0];
    res.clamped = clamp;
    res.degenerate = degen;
    return res;
  endfunction

  task automatic report(input string what, input rsp_t got, input rsp_t want);
    $display("%0t mismatch %s: got x=%0d y=%0d c=%0b d=%0b want x=%0d y=%0d c=%0b d=%0b",
             $realtime, what, got.grid_x, got.grid_y, got.clamped, got.degenerate,
             want.grid_x, want.grid_y, want.clamped, want.degenerate);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CURVES; i++) curve_regs[i] <= '0;
      width_reg  <= GRID_WIDTH_RST;
      height_reg <= GRID_HEIGHT_RST;
      expected_points.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index < NUM_CURVES) curve_regs[cfg_index] <= cfg_data;
        else if (cfg_index == REG_GRID_WIDTH) width_reg <= cfg_data[GRID_W-1:0];
        else if (cfg_index == REG_GRID_HEIGHT) height_reg <= cfg_data[GRID_W-1:0];
      end
      if (req_valid && req_ready) expected_points.push_back(predict_point(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_points.size() == 0) begin
          report("unexpected response", rsp_data, '0);
        end else begin
          rsp_t want;
          want = expected_points.pop_front();
          if (rsp_data.grid_x !== want.grid_x) report("grid_x", rsp_data, want);
          if (rsp_data.grid_y !== want.grid_y) report("grid_y", rsp_data, want);
          if (rsp_data.clamped !== want.clamped) report("clamped", rsp_data, want);
          if (rsp_data.degenerate !== want.degenerate) report("degenerate", rsp_data, want);
        end
      end
    end
  end

endmodule

// ===== verif/tb_curved_grid_point_mapper_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the curved grid point mapper: drives requests, register
// settings and response backpressure. Depends on cgpm_pkg, the mapper unit and the checker.
module tb_curved_grid_point_mapper_unit;
  import cgpm_pkg::*;

  localparam int LIMIT = 200000;
  localparam int DRAIN = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   stall_left = 0;
  bit                   quiet = 1'b0;
  logic [CFG_W-1:0]     settings [8];

  always #4 clk = ~clk;

  curved_grid_point_mapper_unit u_top (.*);

  curved_grid_point_mapper_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left = $urandom_range(2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic logic [CFG_W-1:0] pack_curve(input int a, input int b, input int c);
    logic [20:0] fa, fb, fc;
    fa = a[20:0];
    fb = b[20:0];
    fc = c[20:0];
    return {fc, fb, fa};
  endfunction

  task automatic send_point(input int x, input int y);
    req_t rq;
    rq.cam_x = x[CAM_W-1:0];
    rq.cam_y = y[CAM_W-1:0];
    if (!quiet && $urandom_range(3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic apply_settings();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= settings[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // small random bow on a frame curve placed near pos pixels
  function automatic logic [CFG_W-1:0] bowed(input int pos);
    return pack_curve($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512,
                      (pos << 8) + $urandom_range(0, 2048) - 1024);
  endfunction

  task automatic frame_settings(input int w, input int h);
    settings[REG_TOP]         = bowed(20);
    settings[REG_MID_ROW]     = bowed(256);
    settings[REG_BOTTOM]      = bowed(490);
    settings[REG_LEFT]        = bowed(20);
    settings[REG_MID_COL]     = bowed(256);
    settings[REG_RIGHT]       = bowed(490);
    settings[REG_GRID_WIDTH]  = CFG_W'(w);
    settings[REG_GRID_HEIGHT] = CFG_W'(h);
  endtask

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) send_point($urandom_range(511), $urandom_range(511));
      else send_point($urandom_range(15, 495), $urandom_range(15, 495));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset curves are all zero: every point is degenerate
    send_point(0, 0);
    send_point(511, 511);
    send_point(0, 511);
    send_point(511, 0);

    // straight frame, exact curve hits and the four corners
    settings[REG_TOP]         = pack_curve(0, 0, 20 << 8);
    settings[REG_MID_ROW]     = pack_curve(0, 0, 256 << 8);
    settings[REG_BOTTOM]      = pack_curve(0, 0, 490 << 8);
    settings[REG_LEFT]        = pack_curve(0, 0, 20 << 8);
    settings[REG_MID_COL]     = pack_curve(0, 0, 256 << 8);
    settings[REG_RIGHT]       = pack_curve(0, 0, 490 << 8);
    settings[REG_GRID_WIDTH]  = CFG_W'(320);
    settings[REG_GRID_HEIGHT] = CFG_W'(200);
    apply_settings();
    send_point(0, 0);
    send_point(511, 511);
    send_point(0, 511);
    send_point(511, 0);
    send_point(256, 256);
    send_point(255, 255);
    send_point(20, 20);
    send_point(490, 490);
    send_point(19, 491);
    send_point(100, 400);
    send_point(400, 100);

    // mid row equals top, right equals mid column: upper and right halves degenerate
    settings[REG_MID_ROW] = settings[REG_TOP];
    settings[REG_RIGHT]   = settings[REG_MID_COL];
    apply_settings();
    send_point(10, 10);
    send_point(300, 300);
    send_point(511, 511);

    frame_settings(320, 200);
    apply_settings();
    random_points(150);

    frame_settings(4095, 4095);
    apply_settings();
    random_points(150);

    frame_settings(1, 1);
    apply_settings();
    random_points(100);

    frame_settings(0, 4095);
    apply_settings();
    random_points(100);

    // arbitrary register contents
    for (int i = 0; i < 8; i++) settings[i] = CFG_W'({$urandom, $urandom});
    apply_settings();
    random_points(100);

    for (int i = 0; i < 8; i++) settings[i] = '1;
    apply_settings();
    random_points(50);

    // flipped frame
    settings[REG_TOP]    = pack_curve(0, 0, 490 << 8);
    settings[REG_BOTTOM] = pack_curve(0, 0, 20 << 8);
    settings[REG_LEFT]   = pack_curve(-1048576, 1048575, -1048576);
    settings[REG_RIGHT]  = pack_curve(1048575, -1048576, 1048575);
    settings[REG_MID_ROW] = pack_curve(0, 0, 256 << 8);
    settings[REG_MID_COL] = pack_curve(0, 0, 256 << 8);
    settings[REG_GRID_WIDTH]  = CFG_W'(2);
    settings[REG_GRID_HEIGHT] = CFG_W'(3);
    apply_settings();
    random_points(100);

    frame_settings(640, 480);
    apply_settings();
    quiet = 1'b1;
    random_points(100);

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cgpm_pkg.sv
src/cgpm_front.sv
src/cgpm_queue.sv
src/cgpm_back.sv
src/curved_grid_point_mapper_unit.sv
verif/curved_grid_point_mapper_checker.sv
verif/tb_curved_grid_point_mapper_unit.sv
